// ===== hdl/racb_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// racb_pkg
// Shared types and codes for the range add / count below block.
// ----------------------------------------------------------------------------
package racb_pkg;

  localparam int IDX_W   = 10;
  localparam int VAL_W   = 32;
  localparam int LEN_W   = 11;
  localparam int COUNT_W = 11;

  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_COUNT = 2'd2;

  localparam logic [LEN_W-1:0] LEN_RESET = 11'd1024;

  // Command word handed from cell to cell along the chain
  typedef struct packed {
    logic             valid;
    logic             wr;
    logic             add;
    logic             cnt;
    logic [IDX_W-1:0] lo;
    logic [IDX_W-1:0] hi;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_t;

endpackage

// ===== hdl/racb_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// racb_if
// Valid/ready channels of the range add / count below block.
// ----------------------------------------------------------------------------
interface racb_item_if;
  logic                         valid;
  logic                         ready;
  logic [1:0]                   opcode;
  logic [racb_pkg::IDX_W-1:0]   first_index;
  logic [racb_pkg::IDX_W-1:0]   last_index;
  logic signed [racb_pkg::VAL_W-1:0] operand_value;

  modport source(output valid, opcode, first_index, last_index, operand_value,
                 input ready);
  modport sink(input valid, opcode, first_index, last_index, operand_value,
               output ready);
endinterface

interface racb_result_if;
  logic                         valid;
  logic                         ready;
  logic [racb_pkg::COUNT_W-1:0] below_count;
  logic                         rejected;

  modport source(output valid, below_count, rejected, input ready);
  modport sink(input valid, below_count, rejected, output ready);
endinterface

interface racb_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [racb_pkg::LEN_W-1:0] data;

  modport source(output valid, data, input ready);
  modport sink(input valid, data, output ready);
endinterface

// ===== hdl/racb_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// racb_cell
// One bank of the value store: holds element row*CELLS+CELL_IDX of each row,
// does a read-modify-write or compare per row and passes the word on.
// ----------------------------------------------------------------------------
module racb_cell #(
  parameter int ROWS      = 64,
  parameter int RW        = 6,
  parameter int CELL_BITS = 4,
  parameter int CELL_IDX  = 0
) (
  input  logic                 clk,
  input  logic                 rst,
  input  racb_pkg::cmd_t       cmd_in,
  input  logic [RW-1:0]        row_in,
  input  logic [CELL_BITS:0]   cnt_in,
  output racb_pkg::cmd_t       cmd_out,
  output logic [RW-1:0]        row_out,
  output logic [CELL_BITS:0]   cnt_out
);

  localparam int XW = RW + CELL_BITS;
  localparam int CW = (XW > racb_pkg::IDX_W) ? XW : racb_pkg::IDX_W;

  logic [racb_pkg::VAL_W-1:0] mem [ROWS];

  racb_pkg::cmd_t             cmd_a;
  logic [RW-1:0]              row_a;
  logic [CELL_BITS:0]         cnt_a;
  logic [racb_pkg::VAL_W-1:0] rd;

  logic [CW-1:0]              elem;
  logic                       sel;
  logic                       hit;
  logic                       we;
  logic [racb_pkg::VAL_W-1:0] wdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_a.valid <= 1'b0;
    end else begin
      cmd_a <= cmd_in;
    end
    row_a <= row_in;
    cnt_a <= cnt_in;
    rd    <= mem[row_in];
  end

  always_comb begin
    elem = CW'({row_a, CELL_BITS'(CELL_IDX)});
    if (cmd_a.wr) begin
      sel = (elem == CW'(cmd_a.lo));
    end else begin
      sel = (elem >= CW'(cmd_a.lo)) && (elem <= CW'(cmd_a.hi));
    end
    hit   = cmd_a.valid && cmd_a.cnt && sel && ($signed(rd) < $signed(cmd_a.value));
    we    = cmd_a.valid && sel && (cmd_a.wr || cmd_a.add);
    wdata = cmd_a.wr ? cmd_a.value : (rd + cmd_a.value);
  end

  // rows of one sweep differ, so the write never meets a read of the same row
  always_ff @(posedge clk) begin
    if (we) begin
      mem[row_a] <= wdata;
    end
  end

  assign cmd_out = cmd_a;
  assign row_out = row_a;
  assign cnt_out = cnt_a + {{CELL_BITS{1'b0}}, hit};

endmodule

// ===== hdl/range_add_count_below.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// range_add_count_below
// Signed 32-bit array with element write, range add and range count below.
// ----------------------------------------------------------------------------
// The store is split over a chain of CELLS = 2**CELL_BITS cells; element i
// lives in cell i mod CELLS at row i / CELLS. An accepted range add or count
// injects one word per row from the row of first_index to that of last_index,
// a write one word for the row of first_index, into the head of the chain;
// each cell does a read-modify-write of its element of the row and passes the
// word on, and the per-row counts are summed at the tail. The run time is set
// by the row sweep and the chain length; a rejected item goes straight to the
// hold state. One item is in work at a time, and a new one is taken while the
// previous result still waits at the output.
// ----------------------------------------------------------------------------
module range_add_count_below #(
  parameter int DEPTH     = 1024,
  parameter int CELL_BITS = 4
) (
  input  logic            clk,
  input  logic            rst,
  racb_item_if.sink       items,
  racb_result_if.source   results,
  racb_cfg_if.sink        cfg
);

  localparam int CELLS = 1 << CELL_BITS;
  localparam int ROWS  = (DEPTH + CELLS - 1) / CELLS;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DW    = $clog2(DEPTH + 1);
  localparam int NW    = (DW > racb_pkg::LEN_W) ? DW : racb_pkg::LEN_W;

  racb_pkg::state_t             state;
  logic [racb_pkg::LEN_W-1:0]   active_length;
  racb_pkg::cmd_t               iss_cmd;
  logic [RW-1:0]                iss_row;
  logic [RW-1:0]                last_row;
  logic [racb_pkg::COUNT_W-1:0] acc;
  logic [racb_pkg::COUNT_W-1:0] acc_next;
  logic [racb_pkg::COUNT_W-1:0] pend_count;
  logic                         pend_rej;
  logic                         out_valid;
  logic [racb_pkg::COUNT_W-1:0] out_count;
  logic                         out_rej;

  logic [NW-1:0]                usable;
  logic                         lo_ok;
  logic                         hi_ok;
  logic                         rej;
  logic                         take;
  logic                         out_free;

  racb_pkg::cmd_t               cmd_chain [CELLS+1];
  logic [RW-1:0]                row_chain [CELLS+1];
  logic [CELL_BITS:0]           cnt_chain [CELLS+1];

  // configuration
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_length <= racb_pkg::LEN_RESET;
    end else if (cfg.valid) begin
      active_length <= cfg.data;
    end
  end

  // item check
  always_comb begin
    usable = (NW'(active_length) > NW'(DEPTH)) ? NW'(DEPTH) : NW'(active_length);
    lo_ok  = NW'(items.first_index) < usable;
    hi_ok  = NW'(items.last_index) < usable;
    case (items.opcode)
      racb_pkg::OP_WRITE: rej = !lo_ok;
      racb_pkg::OP_ADD,
      racb_pkg::OP_COUNT: rej = !(lo_ok && hi_ok && (items.first_index <= items.last_index));
      default:            rej = 1'b1;
    endcase
  end

  assign items.ready = (state == racb_pkg::ST_IDLE);
  assign take        = items.valid && items.ready;
  assign out_free    = !out_valid || results.ready;
  assign acc_next    = acc + racb_pkg::COUNT_W'(cnt_chain[CELLS]);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= racb_pkg::ST_IDLE;
      iss_cmd.valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if ((state == racb_pkg::ST_HOLD) && out_free) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        racb_pkg::ST_IDLE: begin
          if (take) begin
            acc <= '0;
            if (rej) begin
              pend_count <= '0;
              pend_rej   <= 1'b1;
              state      <= racb_pkg::ST_HOLD;
            end else begin
              iss_cmd.valid <= 1'b1;
              iss_cmd.wr    <= (items.opcode == racb_pkg::OP_WRITE);
              iss_cmd.add   <= (items.opcode == racb_pkg::OP_ADD);
              iss_cmd.cnt   <= (items.opcode == racb_pkg::OP_COUNT);
              iss_cmd.lo    <= items.first_index;
              iss_cmd.hi    <= items.last_index;
              iss_cmd.value <= items.operand_value;
              iss_row       <= RW'(items.first_index >> CELL_BITS);
              if (items.opcode == racb_pkg::OP_WRITE) begin
                last_row <= RW'(items.first_index >> CELL_BITS);
              end else begin
                last_row <= RW'(items.last_index >> CELL_BITS);
              end
              state <= racb_pkg::ST_RUN;
            end
          end
        end
        racb_pkg::ST_RUN: begin
          // advance the row sweep, drop the word after the last row
          if (iss_cmd.valid) begin
            if (iss_row == last_row) begin
              iss_cmd.valid <= 1'b0;
            end else begin
              iss_row <= iss_row + 1'b1;
            end
          end
          if (cmd_chain[CELLS].valid) begin
            acc <= acc_next;
            if (row_chain[CELLS] == last_row) begin
              pend_count <= acc_next;
              pend_rej   <= 1'b0;
              state      <= racb_pkg::ST_HOLD;
            end
          end
        end
        racb_pkg::ST_HOLD: begin
          if (out_free) begin
            out_count <= pend_count;
            out_rej   <= pend_rej;
            state     <= racb_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= racb_pkg::ST_IDLE;
        end
      endcase
    end
  end

  assign results.valid       = out_valid;
  assign results.below_count = out_count;
  assign results.rejected    = out_rej;

  // chain of cells
  assign cmd_chain[0] = iss_cmd;
  assign row_chain[0] = iss_row;
  assign cnt_chain[0] = '0;

  for (genvar k = 0; k < CELLS; k++) begin : g_cell
    racb_cell #(
      .ROWS      (ROWS),
      .RW        (RW),
      .CELL_BITS (CELL_BITS),
      .CELL_IDX  (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd_in  (cmd_chain[k]),
      .row_in  (row_chain[k]),
      .cnt_in  (cnt_chain[k]),
      .cmd_out (cmd_chain[k+1]),
      .row_out (row_chain[k+1]),
      .cnt_out (cnt_chain[k+1])
    );
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the range add / count below array. A shadow copy of
// the store and of the length register predicts every result; a checker
// compares each result word with the oldest prediction. Stimulus loads the
// low rows and the top row of the store, runs directed corner cases and length
// settings, then random traffic under varying idle patterns and long output
// stalls. Adds and counts only ever cover entries that were written.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int STORE_DEPTH = 1024;
  localparam int FILL_LOW    = 128;
  localparam int FILL_HIGH   = 1008;
  localparam int CYCLE_LIMIT = 1000000;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [racb_pkg::COUNT_W-1:0] below_count;
    logic                         rejected;
  } outcome_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  racb_item_if   items_ch();
  racb_result_if results_ch();
  racb_cfg_if    cfg_ch();

  range_add_count_below i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (items_ch),
    .results (results_ch),
    .cfg     (cfg_ch)
  );

  logic [racb_pkg::VAL_W-1:0] shadow_store [STORE_DEPTH];
  logic                       written [STORE_DEPTH];
  logic [racb_pkg::LEN_W-1:0] len_setting = racb_pkg::LEN_RESET;
  outcome_t                   pending_outcomes [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left     = 0;
  int items_sent    = 0;
  int results_seen  = 0;
  int error_count   = 0;

  always #5 clk = ~clk;

  initial begin
    items_ch.valid         = 1'b0;
    items_ch.opcode        = racb_pkg::OP_WRITE;
    items_ch.first_index   = '0;
    items_ch.last_index    = '0;
    items_ch.operand_value = '0;
    results_ch.ready       = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.data            = '0;
    for (int i = 0; i < STORE_DEPTH; i++) written[i] = 1'b0;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  // Receiver: long hold when requested, else random idling
  always @(negedge clk) begin
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      results_ch.ready <= 1'b0;
    end else begin
      results_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  function automatic int usable_len();
    return (len_setting > STORE_DEPTH) ? STORE_DEPTH : int'(len_setting);
  endfunction

  // Last index from lo on with every entry up to it written; -1 when lo is not
  function automatic int written_end(input int lo, input int hi);
    int last;
    last = -1;
    for (int i = lo; i <= hi; i++) begin
      if (!written[i]) break;
      last = i;
    end
    return last;
  endfunction

  // Apply one command to the shadow store and return its result word
  function automatic outcome_t apply_command(input logic [1:0] op,
                                             input logic [racb_pkg::IDX_W-1:0] lo,
                                             input logic [racb_pkg::IDX_W-1:0] hi,
                                             input logic [racb_pkg::VAL_W-1:0] val);
    outcome_t res;
    int       n;
    int       count;
    res.below_count = '0;
    res.rejected    = 1'b0;
    n               = usable_len();
    count           = 0;
    case (op)
      racb_pkg::OP_WRITE: begin
        if (lo < n) begin
          shadow_store[lo] = val;
          written[lo]      = 1'b1;
        end else begin
          res.rejected = 1'b1;
        end
      end
      racb_pkg::OP_ADD, racb_pkg::OP_COUNT: begin
        if (lo >= n || hi >= n || lo > hi) begin
          res.rejected = 1'b1;
        end else begin
          for (int i = lo; i <= hi; i++) begin
            if (op == racb_pkg::OP_ADD) shadow_store[i] = shadow_store[i] + val;
            else if ($signed(shadow_store[i]) < $signed(val)) count++;
          end
        end
      end
      default: res.rejected = 1'b1;
    endcase
    res.below_count = racb_pkg::COUNT_W'(count);
    return res;
  endfunction

  always @(posedge clk) begin : check_results
    outcome_t want;
    if (!rst && results_ch.valid && results_ch.ready) begin
      results_seen++;
      if (pending_outcomes.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with nothing expected", results_seen));
      end else begin
        want = pending_outcomes.pop_front();
        if (results_ch.below_count !== want.below_count)
          report_mismatch($sformatf("result %0d: below_count %0d, expected %0d",
                                    results_seen, results_ch.below_count, want.below_count));
        if (results_ch.rejected !== want.rejected)
          report_mismatch($sformatf("result %0d: rejected %0b, expected %0b",
                                    results_seen, results_ch.rejected, want.rejected));
      end
    end
  end

  // Offer one word; called and returning at a falling edge
  task automatic send_item(input logic [1:0] op, input logic [racb_pkg::IDX_W-1:0] lo,
                           input logic [racb_pkg::IDX_W-1:0] hi,
                           input logic [racb_pkg::VAL_W-1:0] val);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      items_ch.valid <= 1'b0;
      @(negedge clk);
    end
    items_ch.valid         <= 1'b1;
    items_ch.opcode        <= op;
    items_ch.first_index   <= lo;
    items_ch.last_index    <= hi;
    items_ch.operand_value <= val;
    do @(posedge clk); while (!items_ch.ready);
    pending_outcomes.push_back(apply_command(op, lo, hi, val));
    items_sent++;
    @(negedge clk);
  endtask

  // Keep accepted adds and counts on written entries; an unwritten start
  // becomes a write there
  task automatic send_checked(input logic [1:0] op, input int lo, input int hi,
                              input logic [racb_pkg::VAL_W-1:0] val);
    int n;
    int last;
    n = usable_len();
    if ((op == racb_pkg::OP_ADD || op == racb_pkg::OP_COUNT) &&
        lo < n && hi < n && lo <= hi) begin
      last = written_end(lo, hi);
      if (last < 0)
        send_item(racb_pkg::OP_WRITE, racb_pkg::IDX_W'(lo), racb_pkg::IDX_W'(hi), val);
      else
        send_item(op, racb_pkg::IDX_W'(lo), racb_pkg::IDX_W'(last), val);
    end else begin
      send_item(op, racb_pkg::IDX_W'(lo), racb_pkg::IDX_W'(hi), val);
    end
  endtask

  // Drop valid and hold until every expected result is back
  task automatic wait_idle();
    items_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_outcomes.size() != 0) @(negedge clk);
  endtask

  task automatic set_length(input logic [racb_pkg::LEN_W-1:0] len);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    do @(posedge clk); while (!cfg_ch.ready);
    len_setting = len;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [racb_pkg::VAL_W-1:0] pick_value(input int span);
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2, 3:    return $urandom();
      default: return racb_pkg::VAL_W'(int'($urandom_range(0, 2 * span)) - span);
    endcase
  endfunction

  task automatic send_random_item();
    int         n;
    int         lo;
    int         hi;
    int         roll;
    int         w;
    logic [1:0] op;
    n    = usable_len();
    roll = $urandom_range(0, 99);
    if (roll < 6) begin
      send_checked(2'($urandom_range(0, 3)), int'($urandom_range(0, STORE_DEPTH - 1)),
                   int'($urandom_range(0, STORE_DEPTH - 1)), $urandom());
    end else if (roll < 10) begin
      // empty range, possibly out of range as well
      lo = $urandom_range(1, STORE_DEPTH - 1);
      hi = $urandom_range(0, lo - 1);
      op = $urandom_range(0, 1) ? racb_pkg::OP_ADD : racb_pkg::OP_COUNT;
      send_item(op, racb_pkg::IDX_W'(lo), racb_pkg::IDX_W'(hi), pick_value(300));
    end else begin
      lo   = $urandom_range(0, n - 1);
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        w = $urandom_range(0, 31);
      end else if (roll < 90) begin
        w = $urandom_range(0, 255);
      end else begin
        lo = 0;
        w  = STORE_DEPTH - 1;
      end
      hi   = (lo + w > n - 1) ? n - 1 : lo + w;
      roll = $urandom_range(0, 99);
      if (roll < 30)
        send_item(racb_pkg::OP_WRITE, racb_pkg::IDX_W'(lo), racb_pkg::IDX_W'($urandom),
                  pick_value(256));
      else if (roll < 60)
        send_checked(racb_pkg::OP_ADD, lo, hi, pick_value(16));
      else
        send_checked(racb_pkg::OP_COUNT, lo, hi, pick_value(300));
    end
  endtask

  // Load the low rows and the top row; later reads stay on written entries
  task automatic test_fill_store();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < FILL_LOW; i++)
      send_item(racb_pkg::OP_WRITE, racb_pkg::IDX_W'(i), racb_pkg::IDX_W'($urandom),
                pick_value(256));
    for (int i = FILL_HIGH; i < STORE_DEPTH; i++)
      send_item(racb_pkg::OP_WRITE, racb_pkg::IDX_W'(i), racb_pkg::IDX_W'($urandom),
                pick_value(256));
  endtask

  task automatic test_directed_cases();
    send_item(racb_pkg::OP_WRITE, 10'd0, 10'd1023, 32'h7fff_ffff);
    send_item(racb_pkg::OP_WRITE, 10'd1023, 10'd0, 32'h8000_0000);
    send_item(racb_pkg::OP_COUNT, 10'd0, 10'd127, 32'h8000_0000);
    send_item(racb_pkg::OP_COUNT, 10'd1008, 10'd1023, 32'h7fff_ffff);
    // wrap at both ends of the signed range
    send_item(racb_pkg::OP_ADD, 10'd0, 10'd0, 32'd1);
    send_item(racb_pkg::OP_ADD, 10'd1023, 10'd1023, 32'hffff_ffff);
    send_item(racb_pkg::OP_COUNT, 10'd0, 10'd0, 32'd0);
    send_item(racb_pkg::OP_COUNT, 10'd1023, 10'd1023, 32'h7fff_ffff);
    send_item(racb_pkg::OP_ADD, 10'd0, 10'd127, 32'h4000_0000);
    send_item(racb_pkg::OP_COUNT, 10'd0, 10'd127, 32'd0);
    send_item(racb_pkg::OP_ADD, 10'd0, 10'd127, 32'hc000_0000);
    send_item(racb_pkg::OP_ADD, 10'd5, 10'd4, 32'd7);
    send_item(racb_pkg::OP_COUNT, 10'd1023, 10'd0, 32'd0);
    send_item(OP_UNUSED, 10'd1023, 10'd1023, 32'hffff_ffff);
    send_item(racb_pkg::OP_ADD, 10'd16, 10'd31, pick_value(16));
    send_item(racb_pkg::OP_COUNT, 10'd15, 10'd32, pick_value(300));
  endtask

  task automatic test_length_limits();
    set_length(11'd1);
    send_item(racb_pkg::OP_WRITE, 10'd0, 10'd5, pick_value(256));
    send_item(racb_pkg::OP_WRITE, 10'd1, 10'd0, pick_value(256));
    send_item(racb_pkg::OP_COUNT, 10'd0, 10'd0, 32'h7fff_ffff);
    send_item(racb_pkg::OP_ADD, 10'd0, 10'd1, 32'd3);
    set_length(11'd0);
    send_item(racb_pkg::OP_WRITE, 10'd0, 10'd0, 32'd1);
    send_item(racb_pkg::OP_COUNT, 10'd0, 10'd0, 32'h7fff_ffff);
    set_length(11'd2047);
    send_item(racb_pkg::OP_ADD, 10'd1008, 10'd1023, 32'd5);
    send_item(racb_pkg::OP_COUNT, 10'd1008, 10'd1023, 32'd0);
    set_length(11'd1024);
  endtask

  task automatic test_random_traffic();
    int send_plan [3] = '{10, 60, 0};
    int recv_plan [3] = '{60, 10, 0};
    int roll;
    for (int p = 0; p < 3; p++) begin
      send_idle_pct = send_plan[p];
      recv_idle_pct = recv_plan[p];
      for (int seg = 0; seg < 4; seg++) begin
        roll = $urandom_range(0, 5);
        if (roll == 0) set_length(11'd1);
        else if (roll == 1) set_length(11'd1024);
        else if (roll == 2) set_length(racb_pkg::LEN_W'($urandom_range(2, 40)));
        else set_length(racb_pkg::LEN_W'($urandom_range(2, 1023)));
        repeat (18) send_random_item();
      end
    end
  endtask

  // Hold the output for a long stretch while words keep coming
  task automatic test_output_stall();
    set_length(11'd1024);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_left     = 400;
    repeat (12) send_random_item();
  endtask

  task automatic test_sender_pause();
    send_idle_pct = 10;
    recv_idle_pct = 30;
    repeat (6) send_random_item();
    wait_idle();
    repeat (6) send_random_item();
  endtask

  initial begin
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_fill_store();
    test_directed_cases();
    test_length_limits();
    test_random_traffic();
    test_output_stall();
    test_sender_pause();
    wait_idle();
    repeat (100) @(negedge clk);
    $display("Run covered %0d items and %0d checked results", items_sent, results_seen);
    $display("Writes, range adds, counts, rejects, lengths 0 to 2047, stalls on both sides");
    if (error_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
